FILE: design/ufu_pkg.sv
package ufu_pkg;

  // Framing symbols on the serial line
  localparam logic [7:0] SYM_OPEN = 8'h7D;
  localparam logic [7:0] SYM_END  = 8'h7E;
  localparam logic [7:0] SYM_ESC  = 8'h7F;

  // An escaped code n in ESC_CODE_LO..ESC_CODE_HI decodes to ESC_BASE + n
  localparam logic [7:0] ESC_BASE    = 8'h7C;
  localparam logic [7:0] ESC_CODE_LO = 8'h01;
  localparam logic [7:0] ESC_CODE_HI = 8'h03;

  // Frame type codes carried in the first decoded byte
  localparam logic [7:0] TYPE_ACK  = 8'h00;
  localparam logic [7:0] TYPE_DATA = 8'h01;
  localparam logic [7:0] TYPE_CMD  = 8'h02;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_FRAME  = 2'd1,
    MODE_ESCAPE = 2'd2
  } rx_mode_e;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_ACK     = 3'd1,
    EV_DATA    = 3'd2,
    EV_CMD     = 3'd3,
    EV_DROP    = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    DROP_NONE    = 3'd0,
    DROP_RESTART = 3'd1,
    DROP_BAD_ESC = 3'd2,
    DROP_OVERFLOW = 3'd3,
    DROP_BAD_TYPE = 3'd4,
    DROP_NO_CMD  = 3'd5
  } drop_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [7:0]  byte_index;
    logic [8:0]  frame_length;
    logic [7:0]  command;
    logic        send_ack;
    drop_e       drop_reason;
  } result_t;

  localparam int TDATA_W = 48;
  localparam int TUSER_W = 3;

endpackage

FILE: design/ufu_decode.sv
module ufu_decode #(
  parameter int MAX_FRAME = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output ufu_pkg::result_t res_o
);
  import ufu_pkg::*;

  localparam int CntW  = $clog2(MAX_FRAME + 1);
  localparam int WideW = (CntW > 9) ? CntW : 9;

  rx_mode_e          mode_q, mode_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        cmd_q, cmd_d;
  logic              ovf_q, ovf_d;

  logic              do_store;
  logic              do_close;
  logic              do_open;
  logic [7:0]        store_val;
  logic [WideW-1:0]  cnt_m1;
  logic              res_valid;
  result_t           res;

  assign cnt_m1 = WideW'(cnt_q) - WideW'(1);

  always_comb begin
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    type_d    = type_q;
    cmd_d     = cmd_q;
    ovf_d     = ovf_q;
    do_store  = 1'b0;
    do_close  = 1'b0;
    do_open   = 1'b0;
    store_val = byte_i;
    res_valid = 1'b0;
    res       = '0;

    case (mode_q)
      MODE_FRAME: begin
        if (byte_i == SYM_OPEN) begin
          do_open = 1'b1;
          res_valid = 1'b1;
          res.event_res = EV_DROP;
          res.drop_reason = DROP_RESTART;
        end else if (byte_i == SYM_END) begin
          do_close = 1'b1;
        end else if (byte_i == SYM_ESC) begin
          mode_d = MODE_ESCAPE;
        end else begin
          do_store = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        if (byte_i == SYM_OPEN) begin
          do_open = 1'b1;
          res_valid = 1'b1;
          res.event_res = EV_DROP;
          res.drop_reason = DROP_RESTART;
        end else if (byte_i >= ESC_CODE_LO && byte_i <= ESC_CODE_HI) begin
          do_store  = 1'b1;
          store_val = ESC_BASE + byte_i;
        end else begin
          mode_d = MODE_IDLE;
          res_valid = 1'b1;
          res.event_res = EV_DROP;
          res.drop_reason = DROP_BAD_ESC;
        end
      end
      default: begin
        if (byte_i == SYM_OPEN) begin
          do_open = 1'b1;
        end else begin
          mode_d = MODE_IDLE;
        end
      end
    endcase

    if (do_open) begin
      mode_d = MODE_FRAME;
      cnt_d  = '0;
      type_d = '0;
      cmd_d  = '0;
      ovf_d  = 1'b0;
    end

    // Keep a decoded byte; the first one is the frame type
    if (do_store) begin
      mode_d = MODE_FRAME;
      if (ovf_q || cnt_q >= CntW'(MAX_FRAME)) begin
        ovf_d = 1'b1;
      end else if (cnt_q == '0) begin
        type_d = store_val;
        cnt_d  = CntW'(1);
      end else begin
        if (cnt_q == CntW'(1)) begin
          cmd_d = store_val;
        end
        cnt_d = cnt_q + CntW'(1);
        res_valid = 1'b1;
        res.event_res  = EV_PAYLOAD;
        res.data_byte  = store_val;
        res.byte_index = cnt_m1[7:0];
      end
    end

    if (do_close) begin
      mode_d = MODE_IDLE;
      res_valid = 1'b1;
      if (cnt_q == '0) begin
        res.event_res = EV_DROP;
        res.drop_reason = DROP_BAD_TYPE;
      end else if (ovf_q) begin
        res.event_res = EV_DROP;
        res.drop_reason = DROP_OVERFLOW;
      end else if (type_q == TYPE_ACK) begin
        res.event_res = EV_ACK;
        res.frame_length = cnt_m1[8:0];
      end else if (type_q == TYPE_DATA) begin
        res.event_res = EV_DATA;
        res.frame_length = cnt_m1[8:0];
        res.send_ack = 1'b1;
      end else if (type_q == TYPE_CMD) begin
        if (cnt_q == CntW'(1)) begin
          res.event_res = EV_DROP;
          res.drop_reason = DROP_NO_CMD;
        end else begin
          res.event_res = EV_CMD;
          res.frame_length = cnt_m1[8:0];
          res.command = cmd_q;
          res.send_ack = 1'b1;
        end
      end else begin
        res.event_res = EV_DROP;
        res.drop_reason = DROP_BAD_TYPE;
      end
    end

    res.frame_type = type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
      type_q <= '0;
      cmd_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      type_q <= type_d;
      cmd_q  <= cmd_d;
      ovf_q  <= ovf_d;
    end
  end

  assign res_valid_o = step_i & res_valid;
  assign res_o       = res;

endmodule

FILE: design/ufu_out_reg.sv
module ufu_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  ufu_pkg::result_t               res_i,
  output logic                           free_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ufu_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic [ufu_pkg::TUSER_W-1:0]    m_axis_tuser
);
  import ufu_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot frees when empty or when the held item is taken this cycle
  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.event_res;
  assign m_axis_tdata  = {3'b000, res_q.drop_reason, res_q.send_ack, res_q.command,
                          res_q.frame_length, res_q.byte_index, res_q.frame_type,
                          res_q.data_byte};

endmodule

FILE: design/uart_frame_unstuffer.sv
// Byte-stuffed frame decoder for a received serial byte stream. 0x7D opens a
// frame, 0x7E closes it and 0x7F escapes the next byte (codes 0x01..0x03 give
// 0x7D..0x7F). The first decoded byte is the frame type (0 ack, 1 data,
// 2 command); each later byte comes out at once as a payload item until the
// frame passes MAX_FRAME decoded bytes, and the closing byte yields one
// frame-done item (with send_ack set for data and command frames) or a drop
// item that names the reason. Bytes outside a frame are swallowed. Each input
// item yields zero or one result item. The block takes one byte per cycle: a
// byte is held in the input register, the decode state is updated as it moves
// on, and any result lands in the output register, which drives tvalid.
// Throughput drops only while the output register is full and tready is low.
module uart_frame_unstuffer #(
  parameter int MAX_FRAME = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // s_axis_tdata: [7:0] rx_byte
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,
  // m_axis_tdata: [7:0] data_byte, [15:8] frame_type, [23:16] byte_index,
  //   [32:24] frame_length, [40:33] command, [41] send_ack,
  //   [44:42] drop_reason, [47:45] zero
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ufu_pkg::TDATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: [2:0] event_res
  output logic [ufu_pkg::TUSER_W-1:0] m_axis_tuser
);
  import ufu_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       advance;
  logic       res_valid;
  result_t    res;

  // Move the held byte on only when the output slot can take a result
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  ufu_decode #(
    .MAX_FRAME(MAX_FRAME)
  ) u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ufu_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_valid),
    .res_i        (res),
    .free_o       (out_free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
